>>> rtl/core/sst_pkg.sv
// sst_pkg: shared types, codes and widths for the small set table
// no dependencies; imported by every module of the block
`default_nettype none

package sst_pkg;

    // fixed field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned OUT_W    = 16;

    // table depth default and limit register reset value
    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = 5'd16;

    // operation codes (the unused code behaves as a membership query)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_MEMBER = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic scan_adv;
        logic scan_hit;
        logic decide;
        logic insert;
        logic del_start;
        logic shift_rd;
        logic shift_wr;
        logic emit;
    } sst_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic at_count;
        logic match;
        logic ins_ok;
        logic del_ok;
        logic out_free;
    } sst_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/small_set_table_unit.sv
// Small set table: an insertion-ordered list of up to DEPTH distinct 32-bit values held in a
// single-port memory. Each input transfer carries an operation in s_tuser (insert, delete,
// membership; the spare code acts as membership) and a value in s_tdata; each gives exactly
// one result transfer with status, found flag, prior position and the count afterwards.
// The memory is walked one entry at a time, each entry read and then compared, so the time
// from acceptance to result grows with the entries ahead of the hit, or with all live entries
// on a miss; a delete then moves each later entry down one place by a read and a write, and
// the next input can be taken in the cycle after the result is loaded. One item is processed
// at a time; a finished result sits in an output register, so a new item is taken while it
// waits, and that item is held at its end until the register frees. The capacity limit is
// to be written by the user through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block itself does not enforce this. Depends on sst_pkg, sst_ctrl and sst_datapath.
`default_nettype none

module small_set_table_unit #(
    parameter int unsigned DEPTH = sst_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // capacity limit register
    input  wire logic                          cfg_wr_en,
    input  wire logic [sst_pkg::COUNT_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sst_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] value
    input  wire logic [sst_pkg::OP_W-1:0]      s_tuser,  // [1:0] op
    // results
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] status, [2] found, [6:3] found_index, [11:7] count, [15:12] zero
    output logic [sst_pkg::OUT_W-1:0]          m_tdata
);
    import sst_pkg::*;

    sst_cmd_t cmd;
    sst_sts_t sts;

    sst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sst_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

>>> rtl/core/sst_datapath.sv
// sst_datapath: table memory, entry count, scan pointer and result register
// depends on sst_pkg; sequenced by sst_ctrl
`default_nettype none

module sst_datapath #(
    parameter int unsigned DEPTH = sst_pkg::DEPTH_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sst_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  wire logic [sst_pkg::VALUE_W-1:0]   s_tdata,
    input  wire logic [sst_pkg::OP_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sst_pkg::OUT_W-1:0]          m_tdata,
    input  wire sst_pkg::sst_cmd_t             cmd,
    output sst_pkg::sst_sts_t                  sts
);
    import sst_pkg::*;

    localparam int unsigned PW   = $clog2(DEPTH + 1);
    localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMPW = (PW > COUNT_W) ? PW : COUNT_W;

    logic [VALUE_W-1:0]  mem [DEPTH];
    logic [VALUE_W-1:0]  rd_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [OP_W-1:0]     op_reg;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  limit_reg;
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg;

    logic [CMPW-1:0]     ptr_ext, cnt_ext, lim_ext, pos_ext;
    logic [PW-1:0]       ptr_plus;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [VALUE_W-1:0]  wr_data;
    logic                full;

    // widened views for compares
    assign ptr_ext  = CMPW'(ptr_reg);
    assign cnt_ext  = CMPW'(cnt_reg);
    assign lim_ext  = CMPW'(limit_reg);
    assign pos_ext  = CMPW'(pos_reg);
    assign ptr_plus = ptr_reg + PW'(1);
    assign full     = (cnt_ext >= lim_ext) || (cnt_ext >= CMPW'(DEPTH));

    // status back to the controller
    assign sts.at_count = (ptr_ext >= cnt_ext);
    assign sts.match    = (rd_reg == value_reg);
    assign sts.ins_ok   = (op_reg == OP_INSERT) && !found_reg && !full;
    assign sts.del_ok   = (op_reg == OP_DELETE) && found_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    // memory address and write data selection
    assign rd_addr = cmd.shift_rd ? ptr_plus[IW-1:0] : ptr_reg[IW-1:0];
    assign wr_addr = cmd.insert ? cnt_ext[IW-1:0] : ptr_reg[IW-1:0];
    assign wr_data = cmd.insert ? value_reg : rd_reg;

    // table memory, single port
    always_ff @(posedge aclk) begin
        if (cmd.insert || cmd.shift_wr) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd || cmd.shift_rd) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // result status from the scan outcome
    always_comb begin
        case (op_reg)
            OP_INSERT: begin
                if (found_reg) begin
                    status_next = ST_PRESENT;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_DONE;
                end
            end
            default: begin
                status_next = found_reg ? ST_DONE : ST_MISSING;
            end
        endcase
    end

    // pointer, hit and count updates
    always_comb begin
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.load) begin
            ptr_next   = '0;
            pos_next   = '0;
            found_next = 1'b0;
        end
        if (cmd.scan_adv || cmd.shift_wr) begin
            ptr_next = ptr_plus;
        end
        if (cmd.scan_hit) begin
            found_next = 1'b1;
            pos_next   = ptr_reg;
        end
        if (cmd.insert) begin
            cnt_next = cnt_reg + COUNT_W'(1);
        end
        if (cmd.del_start) begin
            cnt_next = cnt_reg - COUNT_W'(1);
            ptr_next = pos_reg;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // item and scan registers
    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        if (cmd.load) begin
            value_reg <= s_tdata;
            op_reg    <= s_tuser;
        end
        if (cmd.decide) begin
            status_reg <= status_next;
        end
        if (cmd.emit) begin
            out_data_reg <= {4'd0, cnt_reg, pos_ext[INDEX_W-1:0], found_reg, status_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/core/sst_ctrl.sv
// sst_ctrl: sequencer for scan, insert, delete shift and result hand-off
// depends on sst_pkg; drives sst_datapath
`default_nettype none

module sst_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire sst_pkg::sst_sts_t  sts,
    output sst_pkg::sst_cmd_t       cmd
);
    import sst_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (sts.at_count) begin
                    state_next = S_DECIDE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (sts.match) begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_DECIDE;
                end else begin
                    cmd.scan_adv = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (sts.ins_ok) begin
                    cmd.insert = 1'b1;
                    state_next = S_FINISH;
                end else if (sts.del_ok) begin
                    cmd.del_start = 1'b1;
                    state_next    = S_SHIFT_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_RD: begin
                if (sts.at_count) begin
                    state_next = S_FINISH;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sst_checker.sv
// sst_checker: port-level checks on the small set table, bound to the top level
// depends on sst_pkg and small_set_table_unit
`default_nettype none

module sst_checker #(
    parameter int unsigned DEPTH = sst_pkg::DEPTH_DEFAULT
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [sst_pkg::OUT_W-1:0]     m_tdata
);
    import sst_pkg::*;

    logic [STATUS_W-1:0] r_status;
    logic                r_found;
    logic [INDEX_W-1:0]  r_index;
    logic [COUNT_W-1:0]  r_count;

    assign r_status = m_tdata[1:0];
    assign r_found  = m_tdata[2];
    assign r_index  = m_tdata[6:3];
    assign r_count  = m_tdata[11:7];

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: ready drops after an input transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // an absent value reports position zero
    a_absent_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !r_found |-> r_index == '0)
        else $error("nonzero position for absent value");

    // status agrees with the found flag
    a_status_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((r_status == ST_PRESENT) && r_found)
                  || ((r_status == ST_FULL) && !r_found)
                  || ((r_status == ST_MISSING) && !r_found)
                  || (r_status == ST_DONE))
        else $error("status inconsistent with found flag");

    // count never exceeds the table depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(r_count) <= DEPTH)
        else $error("count beyond depth");

endmodule

bind small_set_table_unit sst_checker #(
    .DEPTH (DEPTH)
) u_sst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
